// File: rtl/lockin_phase_rotation_defines.svh
// ----------------------------------------------------------------------------
// lockin phase rotation assertion macros
// concurrent checks on clk with asynchronous active-low reset rst_n
// ----------------------------------------------------------------------------
`ifndef LOCKIN_PHASE_ROTATION_DEFINES_SVH
`define LOCKIN_PHASE_ROTATION_DEFINES_SVH

// same-cycle implication
`define LPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// widths, types, register codes, rounding and saturation helpers of the phase rotator
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 16;
    localparam int FRAC       = COEF_W - 1;
    localparam int NUM_CH     = 6;
    localparam int NUM_STAGES = 6;
    localparam int NUM_PROD   = 8;
    localparam int NUM_MID    = 4;
    localparam int NUM_AUX    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int MODE_W     = 2;

    localparam int MID_W   = SAMPLE_W + 2;
    localparam int PROD1_W = SAMPLE_W + COEF_W;
    localparam int SUM1_W  = PROD1_W + 1;
    localparam int PROD2_W = MID_W + COEF_W;
    localparam int SUM2_W  = PROD2_W + 1;
    localparam int RES_W   = SUM2_W - FRAC;
    localparam int TDATA_W = ((NUM_CH * SAMPLE_W + 7) / 8) * 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [MID_W-1:0]    mid_t;
    typedef logic signed [PROD1_W-1:0]  prod1_t;
    typedef logic signed [PROD2_W-1:0]  prod2_t;
    typedef logic signed [RES_W-1:0]    res_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_MOD1,
        REG_SIN_MOD1,
        REG_COS_MOD2,
        REG_SIN_MOD2,
        REG_COS_WAVE,
        REG_SIN_WAVE,
        REG_CHANNEL_MODE
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_TWO,
        MODE_FOUR,
        MODE_SIX
    } mode_t;

    localparam coef_t   COEF_ONE  = {1'b0, {(COEF_W-1){1'b1}}};
    localparam coef_t   COEF_ZERO = '0;
    localparam sample_t SAT_MAX   = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAT_MIN   = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam res_t    RES_MAX   = res_t'(SAT_MAX);
    localparam res_t    RES_MIN   = res_t'(SAT_MIN);

    localparam logic signed [SUM1_W-1:0] HALF1 = SUM1_W'(1) << (FRAC - 1);
    localparam logic signed [SUM2_W-1:0] HALF2 = SUM2_W'(1) << (FRAC - 1);

    // round half up of (a +/- b) / 2^FRAC, first rotation level
    function automatic mid_t round1(input prod1_t a, input prod1_t b, input logic sub);
        logic signed [SUM1_W-1:0] s;
        s = sub ? (SUM1_W'(a) - SUM1_W'(b)) : (SUM1_W'(a) + SUM1_W'(b));
        s = s + HALF1;
        return s[SUM1_W-1:FRAC];
    endfunction

    // round half up of (a +/- b) / 2^FRAC, second rotation level
    function automatic res_t round2(input prod2_t a, input prod2_t b, input logic sub);
        logic signed [SUM2_W-1:0] s;
        s = sub ? (SUM2_W'(a) - SUM2_W'(b)) : (SUM2_W'(a) + SUM2_W'(b));
        s = s + HALF2;
        return s[SUM2_W-1:FRAC];
    endfunction

    function automatic logic is_clip(input res_t v);
        return (v > RES_MAX) || (v < RES_MIN);
    endfunction

    function automatic sample_t clip(input res_t v);
        sample_t r;
        if (v > RES_MAX)
        begin
            r = SAT_MAX;
        end
        else if (v < RES_MIN)
        begin
            r = SAT_MIN;
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/lockin_phase_rotation.sv
// ----------------------------------------------------------------------------
// lockin_phase_rotation
// phase rotation of one lock-in point across up to six channels, saturating
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  in_ch1..in_ch6
//  m_axis    out        m_axis_tvalid / m_axis_tready  out_ch1..out_ch6, saturated
//  cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
//  one transaction per cycle while m_axis_tready does not stall the output
//  stages: input, modulation products, round, wave products, round, saturate
//  reset clears the valid bits and loads identity coefficients, four channels
//  backpressure stops only full stages, empty stages keep filling
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module lockin_phase_rotation (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // in_ch1, in_ch2, in_ch3, in_ch4, in_ch5, in_ch6
    input  logic [lpr_pkg::TDATA_W-1:0]      s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_ch1, out_ch2, out_ch3, out_ch4, out_ch5, out_ch6
    output logic [lpr_pkg::TDATA_W-1:0]      m_axis_tdata,
    // saturated
    output logic                             m_axis_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lpr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpr_pkg::COEF_W-1:0]       cfg_data
);

    import lpr_pkg::*;

    coef_t                 cos_mod1_reg, sin_mod1_reg;
    coef_t                 cos_mod2_reg, sin_mod2_reg;
    coef_t                 cos_wave_reg, sin_wave_reg;
    logic [MODE_W-1:0]     mode_reg;
    logic                  two_ch;
    logic                  six_ch;

    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    logic [NUM_STAGES-1:0] stage_rdy;
    logic [NUM_STAGES-1:0] stage_ld;

    sample_t               s1_x_reg      [NUM_CH];
    sample_t               s1_x_next     [NUM_CH];
    prod1_t                s2_prod_reg   [NUM_PROD];
    prod1_t                s2_prod_next  [NUM_PROD];
    sample_t               s2_x5_reg, s2_x6_reg;
    mid_t                  s3_mid_reg    [NUM_MID];
    mid_t                  s3_mid_next   [NUM_MID];
    sample_t               s3_x5_reg, s3_x6_reg;
    prod2_t                s4_prod_reg   [NUM_PROD];
    prod2_t                s4_prod_next  [NUM_PROD];
    prod1_t                s4_aux_reg    [NUM_AUX];
    prod1_t                s4_aux_next   [NUM_AUX];
    mid_t                  s4_a_reg, s4_c_reg;
    res_t                  s5_res_reg    [NUM_CH];
    res_t                  s5_res_next   [NUM_CH];
    sample_t               out_reg       [NUM_CH];
    sample_t               out_next      [NUM_CH];
    logic                  sat_reg, sat_next;
    sample_t               pair_x;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_mod1_reg <= COEF_ONE;
            sin_mod1_reg <= COEF_ZERO;
            cos_mod2_reg <= COEF_ONE;
            sin_mod2_reg <= COEF_ZERO;
            cos_wave_reg <= COEF_ONE;
            sin_wave_reg <= COEF_ZERO;
            mode_reg     <= MODE_FOUR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COS_MOD1:     cos_mod1_reg <= cfg_data;
                REG_SIN_MOD1:     sin_mod1_reg <= cfg_data;
                REG_COS_MOD2:     cos_mod2_reg <= cfg_data;
                REG_SIN_MOD2:     sin_mod2_reg <= cfg_data;
                REG_COS_WAVE:     cos_wave_reg <= cfg_data;
                REG_SIN_WAVE:     sin_wave_reg <= cfg_data;
                REG_CHANNEL_MODE: mode_reg     <= cfg_data[MODE_W-1:0];
                default:          ;
            endcase
        end
    end

    // mode value three behaves as six channels
    assign two_ch = (mode_reg == MODE_TWO);
    assign six_ch = !two_ch && (mode_reg != MODE_FOUR);

    // pipeline flow control
    always_comb
    begin
        stage_rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_rdy[k] = !vld_reg[k] || stage_rdy[k+1];
        end
        stage_ld = stage_rdy & {vld_reg[NUM_STAGES-2:0], s_axis_tvalid};
        vld_next = vld_reg;
        if (stage_rdy[0])
        begin
            vld_next[0] = s_axis_tvalid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (stage_rdy[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = stage_rdy[0];

    // datapath next values
    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            s1_x_next[k] = s_axis_tdata[k*SAMPLE_W +: SAMPLE_W];
        end

        // in two-channel mode channel two takes the place of channel three
        pair_x = two_ch ? s1_x_reg[1] : s1_x_reg[2];
        s2_prod_next[0] = cos_mod1_reg * s1_x_reg[0];
        s2_prod_next[1] = sin_mod1_reg * pair_x;
        s2_prod_next[2] = cos_mod1_reg * pair_x;
        s2_prod_next[3] = sin_mod1_reg * s1_x_reg[0];
        s2_prod_next[4] = cos_mod2_reg * s1_x_reg[1];
        s2_prod_next[5] = sin_mod2_reg * s1_x_reg[3];
        s2_prod_next[6] = cos_mod2_reg * s1_x_reg[3];
        s2_prod_next[7] = sin_mod2_reg * s1_x_reg[1];

        s3_mid_next[0] = round1(s2_prod_reg[0], s2_prod_reg[1], 1'b0);
        s3_mid_next[1] = round1(s2_prod_reg[4], s2_prod_reg[5], 1'b0);
        s3_mid_next[2] = round1(s2_prod_reg[2], s2_prod_reg[3], 1'b1);
        s3_mid_next[3] = round1(s2_prod_reg[6], s2_prod_reg[7], 1'b1);

        s4_prod_next[0] = cos_wave_reg * s3_mid_reg[0];
        s4_prod_next[1] = sin_wave_reg * s3_mid_reg[1];
        s4_prod_next[2] = cos_wave_reg * s3_mid_reg[1];
        s4_prod_next[3] = sin_wave_reg * s3_mid_reg[0];
        s4_prod_next[4] = cos_wave_reg * s3_mid_reg[2];
        s4_prod_next[5] = sin_wave_reg * s3_mid_reg[3];
        s4_prod_next[6] = cos_wave_reg * s3_mid_reg[3];
        s4_prod_next[7] = sin_wave_reg * s3_mid_reg[2];
        s4_aux_next[0]  = cos_wave_reg * s3_x5_reg;
        s4_aux_next[1]  = sin_wave_reg * s3_x6_reg;
        s4_aux_next[2]  = cos_wave_reg * s3_x6_reg;
        s4_aux_next[3]  = sin_wave_reg * s3_x5_reg;

        if (two_ch)
        begin
            s5_res_next[0] = res_t'(s4_a_reg);
            s5_res_next[1] = res_t'(s4_c_reg);
            s5_res_next[2] = '0;
            s5_res_next[3] = '0;
        end
        else
        begin
            s5_res_next[0] = round2(s4_prod_reg[0], s4_prod_reg[1], 1'b0);
            s5_res_next[1] = round2(s4_prod_reg[2], s4_prod_reg[3], 1'b1);
            s5_res_next[2] = round2(s4_prod_reg[4], s4_prod_reg[5], 1'b0);
            s5_res_next[3] = round2(s4_prod_reg[6], s4_prod_reg[7], 1'b1);
        end
        if (six_ch)
        begin
            s5_res_next[4] = round2(prod2_t'(s4_aux_reg[0]), prod2_t'(s4_aux_reg[1]), 1'b0);
            s5_res_next[5] = round2(prod2_t'(s4_aux_reg[2]), prod2_t'(s4_aux_reg[3]), 1'b1);
        end
        else
        begin
            s5_res_next[4] = '0;
            s5_res_next[5] = '0;
        end

        sat_next = 1'b0;
        for (int k = 0; k < NUM_CH; k++)
        begin
            out_next[k] = clip(s5_res_reg[k]);
            sat_next    = sat_next | is_clip(s5_res_reg[k]);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (stage_ld[0])
        begin
            s1_x_reg <= s1_x_next;
        end
        if (stage_ld[1])
        begin
            s2_prod_reg <= s2_prod_next;
            s2_x5_reg   <= s1_x_reg[4];
            s2_x6_reg   <= s1_x_reg[5];
        end
        if (stage_ld[2])
        begin
            s3_mid_reg <= s3_mid_next;
            s3_x5_reg  <= s2_x5_reg;
            s3_x6_reg  <= s2_x6_reg;
        end
        if (stage_ld[3])
        begin
            s4_prod_reg <= s4_prod_next;
            s4_aux_reg  <= s4_aux_next;
            s4_a_reg    <= s3_mid_reg[0];
            s4_c_reg    <= s3_mid_reg[2];
        end
        if (stage_ld[4])
        begin
            s5_res_reg <= s5_res_next;
        end
        if (stage_ld[5])
        begin
            out_reg <= out_next;
            sat_reg <= sat_next;
        end
    end

    always_comb
    begin
        m_axis_tdata = '0;
        for (int k = 0; k < NUM_CH; k++)
        begin
            m_axis_tdata[k*SAMPLE_W +: SAMPLE_W] = out_reg[k];
        end
    end

    assign m_axis_tvalid = vld_reg[NUM_STAGES-1];
    assign m_axis_tuser  = sat_reg;

    // checks
    `include "lockin_phase_rotation_defines.svh"

    `LPR_ASSERT_NOW(a_ready_low_only_when_full, !s_axis_tready, (&vld_reg) && !m_axis_tready, "input stalled with an empty stage")
    `LPR_ASSERT_NEXT(a_full_stall_holds, (&vld_reg) && !m_axis_tready, &vld_reg, "stalled pipeline lost a transaction")
    `LPR_ASSERT_NOW(a_sat_flag_has_clip, m_axis_tvalid && m_axis_tuser, out_reg[0] == SAT_MAX || out_reg[0] == SAT_MIN || out_reg[1] == SAT_MAX || out_reg[1] == SAT_MIN || out_reg[2] == SAT_MAX || out_reg[2] == SAT_MIN || out_reg[3] == SAT_MAX || out_reg[3] == SAT_MIN || out_reg[4] == SAT_MAX || out_reg[4] == SAT_MIN || out_reg[5] == SAT_MAX || out_reg[5] == SAT_MIN, "saturated flag without a clipped channel")

endmodule
